// ===== rtl/aoc_pkg.sv =====
// shared types, constants and register codes of the alpha-over compositor
package aoc_pkg;

	// default cap on destination dimensions
	localparam int MAX_DIM_DEF = 4096;

	// field widths
	localparam int COORD_W   = 12;
	localparam int CHAN_W    = 8;
	localparam int CFG_W     = 13;
	localparam int CNT_W     = 3;
	localparam int NCH       = 3;
	localparam int NUM_W     = 24;
	localparam int DIVR_W    = 16;
	localparam int DIV_CELLS = 8;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [2:0] {
		REG_PLACE_COL     = 3'd0,
		REG_PLACE_ROW     = 3'd1,
		REG_DEST_WIDTH    = 3'd2,
		REG_DEST_HEIGHT   = 3'd3,
		REG_DEST_CHANNELS = 3'd4,
		REG_SRC_CHANNELS  = 3'd5
	} reg_idx_t;

	// channel count thresholds and alpha limits
	localparam logic [CNT_W-1:0]  CNT_GREEN  = 3'd2;
	localparam logic [CNT_W-1:0]  CNT_BLUE   = 3'd3;
	localparam logic [CNT_W-1:0]  CNT_ALPHA  = 3'd4;
	localparam logic [CHAN_W-1:0] OPAQUE_MIN = 8'd253;
	localparam logic [CHAN_W-1:0] ALPHA_MIN  = 8'd3;
	localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;

	// register reset values
	localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;
	localparam logic [CNT_W-1:0] CNT_RESET = 3'd4;

	typedef struct packed {
		logic [CFG_W-1:0] place_col;
		logic [CFG_W-1:0] place_row;
		logic [CFG_W-1:0] dest_width;
		logic [CFG_W-1:0] dest_height;
		logic [CNT_W-1:0] dest_channels;
		logic [CNT_W-1:0] src_channels;
	} cfg_t;

	// per-pixel data that rides along with the division
	typedef struct packed {
		logic                       we;
		logic [COORD_W-1:0]         col;
		logic [COORD_W-1:0]         row;
		logic                       copy;
		logic                       zero;
		logic [NCH-1:0]             sat;
		logic                       g_en;
		logic                       b_en;
		logic                       a_en;
		logic [CHAN_W-1:0]          oa;
		logic [NCH-1:0][CHAN_W-1:0] scopy;
	} side_t;

	// word handed from cell to cell
	typedef struct packed {
		logic [NCH-1:0][NUM_W-1:0]  rem;
		logic [NUM_W-1:0]           dsh;
		logic [NCH-1:0][CHAN_W-1:0] quo;
		side_t                      side;
	} div_t;

endpackage

// ===== rtl/aoc_if.sv =====
// pixel channel interfaces: source/destination pair in, composited pixel out
interface aoc_pix_in_if import aoc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] src_col;
	logic [COORD_W-1:0] src_row;
	logic [CHAN_W-1:0]  src_red;
	logic [CHAN_W-1:0]  src_green;
	logic [CHAN_W-1:0]  src_blue;
	logic [CHAN_W-1:0]  src_alpha;
	logic [CHAN_W-1:0]  dst_red;
	logic [CHAN_W-1:0]  dst_green;
	logic [CHAN_W-1:0]  dst_blue;
	logic [CHAN_W-1:0]  dst_alpha;

	modport source (
		output valid, src_col, src_row, src_red, src_green, src_blue, src_alpha,
		output dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);
	modport sink (
		input  valid, src_col, src_row, src_red, src_green, src_blue, src_alpha,
		input  dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);
endinterface

interface aoc_pix_out_if import aoc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [COORD_W-1:0] target_col;
	logic [COORD_W-1:0] target_row;
	logic [CHAN_W-1:0]  out_red;
	logic [CHAN_W-1:0]  out_green;
	logic [CHAN_W-1:0]  out_blue;
	logic [CHAN_W-1:0]  out_alpha;

	modport source (
		output valid, write_enable, target_col, target_row,
		output out_red, out_green, out_blue, out_alpha,
		input  ready
	);
	modport sink (
		input  valid, write_enable, target_col, target_row,
		input  out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

// ===== rtl/aoc_front.sv =====
// front end: placement, clipping, alpha selection and numerator/divisor set-up
module aoc_front import aoc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	aoc_pix_in_if.sink      pix_in,
	output logic            dn_valid,
	input  logic            dn_ready,
	output div_t            dn_data
);

	localparam int DIM_W = $clog2(MAX_DIM + 1);
	localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

	// stage valids and ready chain
	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3 = !valid_s3 || dn_ready;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign pix_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= pix_in.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
		end
	end

	// stage 1: target position, clip, channel and alpha selection, first products
	logic [COORD_W+1:0]         tx_c, ty_c;
	logic [CMP_W-1:0]           w_ext, h_ext, w_cap, h_cap;
	logic                       inside_c, gray_c, copy_c;
	logic [CHAN_W-1:0]          sa_c, da_c, nsa_c;
	logic [NCH-1:0][CHAN_W-1:0] sc_c, dc_c;
	logic [DIVR_W-1:0]          w_c;
	logic [NCH-1:0][DIVR_W-1:0] sp_c;
	side_t                      side_c;

	always_comb begin
		tx_c = {2'b00, pix_in.src_col} + {cfg.place_col[CFG_W-1], cfg.place_col};
		ty_c = {2'b00, pix_in.src_row} + {cfg.place_row[CFG_W-1], cfg.place_row};
		w_ext = CMP_W'(cfg.dest_width);
		h_ext = CMP_W'(cfg.dest_height);
		w_cap = (w_ext > MAX_C) ? MAX_C : w_ext;
		h_cap = (h_ext > MAX_C) ? MAX_C : h_ext;
		inside_c = !tx_c[COORD_W+1] && !ty_c[COORD_W+1] &&
			(CMP_W'(tx_c[COORD_W:0]) < w_cap) && (CMP_W'(ty_c[COORD_W:0]) < h_cap);

		gray_c = cfg.src_channels < CNT_BLUE;
		sa_c = (cfg.src_channels >= CNT_ALPHA) ? pix_in.src_alpha : CHAN_MAX;
		da_c = (cfg.dest_channels >= CNT_ALPHA) ? pix_in.dst_alpha : CHAN_MAX;
		nsa_c = ~sa_c;
		copy_c = (sa_c >= OPAQUE_MIN) && (da_c >= OPAQUE_MIN);

		sc_c[0] = pix_in.src_red;
		sc_c[1] = gray_c ? pix_in.src_red : pix_in.src_green;
		sc_c[2] = gray_c ? pix_in.src_red : pix_in.src_blue;
		dc_c[0] = pix_in.dst_red;
		dc_c[1] = pix_in.dst_green;
		dc_c[2] = pix_in.dst_blue;

		w_c = {8'b0, da_c} * {8'b0, nsa_c};
		for (int i = 0; i < NCH; i++) begin
			sp_c[i] = {8'b0, sc_c[i]} * {8'b0, sa_c};
		end

		side_c = '0;
		side_c.we    = inside_c;
		side_c.col   = inside_c ? tx_c[COORD_W-1:0] : '0;
		side_c.row   = inside_c ? ty_c[COORD_W-1:0] : '0;
		side_c.copy  = copy_c;
		side_c.g_en  = cfg.dest_channels >= CNT_GREEN;
		side_c.b_en  = cfg.dest_channels >= CNT_BLUE;
		side_c.a_en  = cfg.dest_channels >= CNT_ALPHA;
		side_c.scopy = sc_c;
	end

	side_t                      side_s1;
	logic [CHAN_W-1:0]          sa_s1;
	logic [DIVR_W-1:0]          w_s1;
	logic [NCH-1:0][DIVR_W-1:0] sp_s1;
	logic [NCH-1:0][CHAN_W-1:0] dc_s1;

	always_ff @(posedge clk) begin
		if (pix_in.valid && rdy_s1) begin
			side_s1 <= side_c;
			sa_s1   <= sa_c;
			w_s1    <= w_c;
			sp_s1   <= sp_c;
			dc_s1   <= dc_c;
		end
	end

	// stage 2: output alpha via divide-by-255, scaled source and weighted destination
	logic [DIVR_W:0]            q255_c;
	logic [CHAN_W:0]            oa_c;
	logic [NCH-1:0][NUM_W-1:0]  s255_c, t1_c;
	side_t                      side2_c;

	always_comb begin
		q255_c = {1'b0, w_s1} + 17'd1 + {9'b0, w_s1[DIVR_W-1:8]};
		oa_c = {1'b0, sa_s1} + {1'b0, q255_c[DIVR_W-1:8]};
		for (int i = 0; i < NCH; i++) begin
			s255_c[i] = {sp_s1[i], 8'b0} - {8'b0, sp_s1[i]};
			t1_c[i] = {16'b0, dc_s1[i]} * {8'b0, w_s1};
		end
		side2_c = side_s1;
		side2_c.oa = side_s1.copy ? sa_s1 : oa_c[CHAN_W-1:0];
		side2_c.zero = !side_s1.copy && (oa_c[CHAN_W-1:0] < ALPHA_MIN);
	end

	side_t                     side_s2;
	logic [CHAN_W-1:0]         oa_s2;
	logic [NCH-1:0][NUM_W-1:0] s255_s2, t1_s2;

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy_s2) begin
			side_s2 <= side2_c;
			oa_s2   <= oa_c[CHAN_W-1:0];
			s255_s2 <= s255_c;
			t1_s2   <= t1_c;
		end
	end

	// stage 3: numerators, divisor 255*oa and the saturation check
	logic [DIVR_W-1:0] d_c;
	div_t              div_c;

	always_comb begin
		d_c = {oa_s2, 8'b0} - {8'b0, oa_s2};
		div_c = '0;
		div_c.side = side_s2;
		div_c.dsh = {1'b0, d_c, 7'b0};
		for (int i = 0; i < NCH; i++) begin
			div_c.rem[i] = s255_s2[i] + t1_s2[i];
			div_c.side.sat[i] = div_c.rem[i] >= {d_c, 8'b0};
		end
	end

	div_t data_s3;

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy_s3) data_s3 <= div_c;
	end

	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

endmodule

// ===== rtl/aoc_div_cell.sv =====
// one restoring-division cell: a quotient bit for each colour lane
module aoc_div_cell import aoc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic up_valid,
	output logic up_ready,
	input  div_t up_data,
	output logic dn_valid,
	input  logic dn_ready,
	output div_t dn_data
);

	logic valid_q;
	div_t data_q;
	div_t nxt;
	logic [NCH-1:0] ge;

	assign up_ready = !valid_q || dn_ready;

	// trial subtract of the shifted divisor, shift it down for the next cell
	always_comb begin
		nxt = up_data;
		for (int i = 0; i < NCH; i++) begin
			ge[i] = up_data.rem[i] >= up_data.dsh;
			nxt.rem[i] = ge[i] ? (up_data.rem[i] - up_data.dsh) : up_data.rem[i];
			nxt.quo[i] = {up_data.quo[i][CHAN_W-2:0], ge[i]};
		end
		nxt.dsh = up_data.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) data_q <= nxt;
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

// ===== rtl/alpha_over_composite_core.sv =====
// top level of the alpha-over compositor: registers, front end, divider chain, result
//
// Source-over-destination compositing, one pixel pair per word.
// pix_in carries a source pixel with its column and row and the destination
// pixel at the matching place; pix_out carries the clipped target position,
// its write enable and the composited colour and alpha. Both use valid/ready.
// Placement offsets, destination size and channel counts are set through the
// APB port and should be written only while no pixel is in flight.
// From acceptance to result valid a word passes three front stages
// (placement and products, output alpha, numerators and divisor) and a row
// of eight division cells, each resolving one quotient bit for all three
// colours. Each stage holds one word, and one pixel is accepted every cycle
// while the receiver is ready. When it stalls, words pile up stage by stage
// and pix_in.ready drops only once every stage is full; empty stages still accept.
// Reset clears all stage valids and returns the registers to zero offsets,
// a 4096 by 4096 destination and four channels on both images.
module alpha_over_composite_core import aoc_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	aoc_pix_in_if.sink        pix_in,
	aoc_pix_out_if.source     pix_out
);

	// configuration registers
	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.place_col     <= '0;
			cfg_q.place_row     <= '0;
			cfg_q.dest_width    <= DIM_RESET;
			cfg_q.dest_height   <= DIM_RESET;
			cfg_q.dest_channels <= CNT_RESET;
			cfg_q.src_channels  <= CNT_RESET;
		end else if (wr_en) begin
			unique case (paddr[ADDR_W-1:2])
				REG_PLACE_COL:     cfg_q.place_col     <= pwdata[CFG_W-1:0];
				REG_PLACE_ROW:     cfg_q.place_row     <= pwdata[CFG_W-1:0];
				REG_DEST_WIDTH:    cfg_q.dest_width    <= pwdata[CFG_W-1:0];
				REG_DEST_HEIGHT:   cfg_q.dest_height   <= pwdata[CFG_W-1:0];
				REG_DEST_CHANNELS: cfg_q.dest_channels <= pwdata[CNT_W-1:0];
				REG_SRC_CHANNELS:  cfg_q.src_channels  <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[ADDR_W-1:2])
			REG_PLACE_COL:     prdata = DATA_W'(cfg_q.place_col);
			REG_PLACE_ROW:     prdata = DATA_W'(cfg_q.place_row);
			REG_DEST_WIDTH:    prdata = DATA_W'(cfg_q.dest_width);
			REG_DEST_HEIGHT:   prdata = DATA_W'(cfg_q.dest_height);
			REG_DEST_CHANNELS: prdata = DATA_W'(cfg_q.dest_channels);
			REG_SRC_CHANNELS:  prdata = DATA_W'(cfg_q.src_channels);
			default:           prdata = '0;
		endcase
	end

	// links between front end and division cells
	logic [DIV_CELLS:0] lnk_valid;
	logic [DIV_CELLS:0] lnk_ready;
	div_t               lnk_data [DIV_CELLS+1];

	aoc_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pix_in   (pix_in),
		.dn_valid (lnk_valid[0]),
		.dn_ready (lnk_ready[0]),
		.dn_data  (lnk_data[0])
	);

	for (genvar g = 0; g < DIV_CELLS; g++) begin : g_cell
		aoc_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (lnk_valid[g]),
			.up_ready (lnk_ready[g]),
			.up_data  (lnk_data[g]),
			.dn_valid (lnk_valid[g+1]),
			.dn_ready (lnk_ready[g+1]),
			.dn_data  (lnk_data[g+1])
		);
	end

	// result selection: copy, transparent, saturated or quotient, then channel masks
	div_t                       fin;
	logic [NCH-1:0][CHAN_W-1:0] col_val;

	assign fin = lnk_data[DIV_CELLS];
	assign lnk_ready[DIV_CELLS] = pix_out.ready;
	assign pix_out.valid = lnk_valid[DIV_CELLS];

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			priority if (fin.side.copy) col_val[i] = fin.side.scopy[i];
			else if (fin.side.zero)     col_val[i] = '0;
			else if (fin.side.sat[i])   col_val[i] = CHAN_MAX;
			else                        col_val[i] = fin.quo[i];
		end
		pix_out.write_enable = fin.side.we;
		pix_out.target_col   = fin.side.col;
		pix_out.target_row   = fin.side.row;
		pix_out.out_red      = fin.side.we ? col_val[0] : '0;
		pix_out.out_green    = (fin.side.we && fin.side.g_en) ? col_val[1] : '0;
		pix_out.out_blue     = (fin.side.we && fin.side.b_en) ? col_val[2] : '0;
		pix_out.out_alpha    = (fin.side.we && fin.side.a_en && !fin.side.zero) ?
			fin.side.oa : '0;
	end

endmodule

// ===== tb/sv/aoc_pixel_checker.sv =====
// pixel checker: tracks register writes, predicts each composited word and compares
module aoc_pixel_checker import aoc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	aoc_pix_in_if             pix_in,
	aoc_pix_out_if            pix_out,
	output int                bad_words,
	output int                words_due
);

	localparam int unsigned FULL = 255;
	localparam int          MAX_REPORTS = 40;

	typedef struct packed {
		logic [COORD_W-1:0]         col;
		logic [COORD_W-1:0]         row;
		logic [NCH-1:0][CHAN_W-1:0] src;
		logic [CHAN_W-1:0]          sa;
		logic [NCH-1:0][CHAN_W-1:0] dst;
		logic [CHAN_W-1:0]          da;
	} pair_t;

	typedef struct packed {
		logic               we;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [CHAN_W-1:0]  alpha;
	} pixel_t;

	// local copy of the register file
	logic [CFG_W-1:0] off_x, off_y, width, height;
	logic [CNT_W-1:0] dst_cnt, src_cnt;

	pixel_t due_pixels [$];
	int     mism;

	// channel count as the block uses it: zero acts as one, above four as four
	function automatic int eff_count(logic [CNT_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > CNT_ALPHA)
			return int'(CNT_ALPHA);
		return int'(c);
	endfunction

	// source over destination for one pair under the current registers
	function automatic pixel_t composite_over(pair_t p);
		int          tx, ty, wmax, hmax, sch, dch;
		int unsigned sa, da, oa, num, q;
		int unsigned sc [NCH];
		int unsigned dc [NCH];
		int unsigned res [NCH];
		pixel_t      r;
		r    = '0;
		tx   = int'(p.col) + int'($signed(off_x));
		ty   = int'(p.row) + int'($signed(off_y));
		wmax = int'(width) > MAX_DIM_DEF ? MAX_DIM_DEF : int'(width);
		hmax = int'(height) > MAX_DIM_DEF ? MAX_DIM_DEF : int'(height);
		sch  = eff_count(src_cnt);
		dch  = eff_count(dst_cnt);
		// clipped target gives an all-zero word
		if (tx < 0 || ty < 0 || tx >= wmax || ty >= hmax)
			return r;
		for (int i = 0; i < NCH; i++) begin
			sc[i] = (sch < int'(CNT_BLUE)) ? int'(p.src[0]) : int'(p.src[i]);
			dc[i] = int'(p.dst[i]);
		end
		sa = (sch == int'(CNT_ALPHA)) ? int'(p.sa) : FULL;
		da = (dch == int'(CNT_ALPHA)) ? int'(p.da) : FULL;
		if (sa >= OPAQUE_MIN && da >= OPAQUE_MIN) begin
			// both nearly opaque: straight copy of the source
			for (int i = 0; i < NCH; i++)
				res[i] = sc[i];
			oa = sa;
		end else begin
			oa = sa + (da * (FULL - sa)) / FULL;
			if (oa < ALPHA_MIN) begin
				for (int i = 0; i < NCH; i++)
					res[i] = 0;
				oa = 0;
			end else begin
				for (int i = 0; i < NCH; i++) begin
					num    = sc[i] * sa * FULL + dc[i] * da * (FULL - sa);
					q      = num / (FULL * oa);
					res[i] = q > FULL ? FULL : q;
				end
			end
		end
		r.we    = 1'b1;
		r.col   = tx[COORD_W-1:0];
		r.row   = ty[COORD_W-1:0];
		r.red   = res[0][CHAN_W-1:0];
		r.green = (dch >= int'(CNT_GREEN)) ? res[1][CHAN_W-1:0] : '0;
		r.blue  = (dch >= int'(CNT_BLUE)) ? res[2][CHAN_W-1:0] : '0;
		r.alpha = (dch == int'(CNT_ALPHA)) ? oa[CHAN_W-1:0] : '0;
		return r;
	endfunction

	// register tracking, prediction on input words, comparison on output words
	always @(posedge clk or negedge arst_n) begin
		pair_t  pr;
		pixel_t got, exp_px;
		if (!arst_n) begin
			off_x   = '0;
			off_y   = '0;
			width   = DIM_RESET;
			height  = DIM_RESET;
			dst_cnt = CNT_RESET;
			src_cnt = CNT_RESET;
			due_pixels.delete();
			mism    = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_PLACE_COL:     off_x   = pwdata[CFG_W-1:0];
					REG_PLACE_ROW:     off_y   = pwdata[CFG_W-1:0];
					REG_DEST_WIDTH:    width   = pwdata[CFG_W-1:0];
					REG_DEST_HEIGHT:   height  = pwdata[CFG_W-1:0];
					REG_DEST_CHANNELS: dst_cnt = pwdata[CNT_W-1:0];
					REG_SRC_CHANNELS:  src_cnt = pwdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready) begin
				pr.col    = pix_in.src_col;
				pr.row    = pix_in.src_row;
				pr.src[0] = pix_in.src_red;
				pr.src[1] = pix_in.src_green;
				pr.src[2] = pix_in.src_blue;
				pr.sa     = pix_in.src_alpha;
				pr.dst[0] = pix_in.dst_red;
				pr.dst[1] = pix_in.dst_green;
				pr.dst[2] = pix_in.dst_blue;
				pr.da     = pix_in.dst_alpha;
				due_pixels.push_back(composite_over(pr));
			end
			if (pix_out.valid && pix_out.ready) begin
				got.we    = pix_out.write_enable;
				got.col   = pix_out.target_col;
				got.row   = pix_out.target_row;
				got.red   = pix_out.out_red;
				got.green = pix_out.out_green;
				got.blue  = pix_out.out_blue;
				got.alpha = pix_out.out_alpha;
				if (due_pixels.size() == 0) begin
					mism++;
					if (mism <= MAX_REPORTS)
						$display({"%0t unexpected word: expected none, got we=%0d ",
							"col=%0d row=%0d rgba=%0d/%0d/%0d/%0d"}, $time,
							got.we, got.col, got.row, got.red,
							got.green, got.blue, got.alpha);
				end else begin
					exp_px = due_pixels.pop_front();
					if (got.we !== exp_px.we || got.col !== exp_px.col ||
						got.row !== exp_px.row || got.red !== exp_px.red ||
						got.green !== exp_px.green || got.blue !== exp_px.blue ||
						got.alpha !== exp_px.alpha) begin
						mism++;
						if (mism <= MAX_REPORTS)
							$display({"%0t word mismatch: expected we=%0d col=%0d row=%0d ",
								"rgba=%0d/%0d/%0d/%0d, got we=%0d col=%0d row=%0d ",
								"rgba=%0d/%0d/%0d/%0d"}, $time,
								exp_px.we, exp_px.col, exp_px.row, exp_px.red,
								exp_px.green, exp_px.blue, exp_px.alpha,
								got.we, got.col, got.row, got.red,
								got.green, got.blue, got.alpha);
					end
				end
			end
		end
		bad_words <= mism;
		words_due <= due_pixels.size();
	end

endmodule

// ===== tb/sv/tb_alpha_over_composite_core.sv =====
// testbench top: clock, reset, register and pixel stimulus, verdict
module tb_alpha_over_composite_core import aoc_pkg::*; ();

	localparam int LATENCY   = 11;
	localparam int LONG_HOLD = 60;
	localparam int N_PHASES  = 12;
	localparam int PHASE_LEN = 88;

	typedef struct packed {
		logic [COORD_W-1:0] src_col;
		logic [COORD_W-1:0] src_row;
		logic [CHAN_W-1:0]  src_red;
		logic [CHAN_W-1:0]  src_green;
		logic [CHAN_W-1:0]  src_blue;
		logic [CHAN_W-1:0]  src_alpha;
		logic [CHAN_W-1:0]  dst_red;
		logic [CHAN_W-1:0]  dst_green;
		logic [CHAN_W-1:0]  dst_blue;
		logic [CHAN_W-1:0]  dst_alpha;
	} pair_word_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int bad_words;
	int words_due;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_req    = 0;

	// register values as the stimulus sees them, used to aim targets inside
	int st_off_x = 0;
	int st_off_y = 0;
	int st_w     = 4096;
	int st_h     = 4096;

	aoc_pix_in_if  pix_in ();
	aoc_pix_out_if pix_out ();

	alpha_over_composite_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_in),
		.pix_out (pix_out)
	);

	aoc_pixel_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.pready    (pready),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.bad_words (bad_words),
		.words_due (words_due)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls plus a long hold-off when the stimulus asks for one
	initial begin : rx_side
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (!arst_n)
				pix_out.ready <= 1'b0;
			else if (hold_left != 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else
				pix_out.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// one register write: setup then access; the caller lowers psel afterwards
	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic set_config(input int ox, input int oy, input int w, input int h,
		input int dch, input int sch);
		cfg_write(REG_PLACE_COL, {{(DATA_W-CFG_W){1'b0}}, ox[CFG_W-1:0]});
		cfg_write(REG_PLACE_ROW, {{(DATA_W-CFG_W){1'b0}}, oy[CFG_W-1:0]});
		cfg_write(REG_DEST_WIDTH, {{(DATA_W-CFG_W){1'b0}}, w[CFG_W-1:0]});
		cfg_write(REG_DEST_HEIGHT, {{(DATA_W-CFG_W){1'b0}}, h[CFG_W-1:0]});
		cfg_write(REG_DEST_CHANNELS, {{(DATA_W-CNT_W){1'b0}}, dch[CNT_W-1:0]});
		cfg_write(REG_SRC_CHANNELS, {{(DATA_W-CNT_W){1'b0}}, sch[CNT_W-1:0]});
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		st_off_x = ox;
		st_off_y = oy;
		st_w     = w;
		st_h     = h;
	endtask

	// offer one pixel pair, with random gaps ahead of it
	task automatic send_pair(input pair_word_t p);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid     <= 1'b1;
		pix_in.src_col   <= p.src_col;
		pix_in.src_row   <= p.src_row;
		pix_in.src_red   <= p.src_red;
		pix_in.src_green <= p.src_green;
		pix_in.src_blue  <= p.src_blue;
		pix_in.src_alpha <= p.src_alpha;
		pix_in.dst_red   <= p.dst_red;
		pix_in.dst_green <= p.dst_green;
		pix_in.dst_blue  <= p.dst_blue;
		pix_in.dst_alpha <= p.dst_alpha;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	// stop offering and wait until every predicted word has come out
	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		do @(posedge clk); while (words_due != 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic pair_word_t make_pair(input int col, input int row,
		input int sr, input int sg, input int sb, input int sa,
		input int dr, input int dg, input int db, input int da);
		pair_word_t p;
		p.src_col   = col[COORD_W-1:0];
		p.src_row   = row[COORD_W-1:0];
		p.src_red   = sr[CHAN_W-1:0];
		p.src_green = sg[CHAN_W-1:0];
		p.src_blue  = sb[CHAN_W-1:0];
		p.src_alpha = sa[CHAN_W-1:0];
		p.dst_red   = dr[CHAN_W-1:0];
		p.dst_green = dg[CHAN_W-1:0];
		p.dst_blue  = db[CHAN_W-1:0];
		p.dst_alpha = da[CHAN_W-1:0];
		return p;
	endfunction

	// colour or alpha level, weighted towards the ends of the range
	function automatic logic [CHAN_W-1:0] pick_level();
		int k;
		k = int'($urandom_range(7));
		if ($urandom_range(2) == 0)
			return (k < 4) ? CHAN_W'(k) : CHAN_W'(248 + k);
		return CHAN_W'($urandom_range(255));
	endfunction

	// source coordinate that mostly lands inside the destination
	function automatic logic [COORD_W-1:0] pick_coord(input int off, input int dim);
		int lim, lo, hi;
		lim = dim > MAX_DIM_DEF ? MAX_DIM_DEF : dim;
		lo  = off < 0 ? -off : 0;
		hi  = lim - 1 - off;
		if (hi > 4095)
			hi = 4095;
		if ($urandom_range(9) < 8 && lo <= hi)
			return COORD_W'($urandom_range(hi, lo));
		return COORD_W'($urandom_range(4095));
	endfunction

	function automatic pair_word_t rand_pair();
		pair_word_t p;
		p.src_col   = pick_coord(st_off_x, st_w);
		p.src_row   = pick_coord(st_off_y, st_h);
		p.src_red   = pick_level();
		p.src_green = pick_level();
		p.src_blue  = pick_level();
		p.src_alpha = pick_level();
		p.dst_red   = pick_level();
		p.dst_green = pick_level();
		p.dst_blue  = pick_level();
		p.dst_alpha = pick_level();
		return p;
	endfunction

	function automatic int pick_offset();
		case ($urandom_range(5))
			0: return 0;
			1: return -4096;
			2: return 4095;
			3: return int'($urandom_range(8191)) - 4096;
			default: return int'($urandom_range(64)) - 32;
		endcase
	endfunction

	function automatic int pick_dim();
		case ($urandom_range(9))
			0: return 0;
			1: return 1;
			2: return 8191;
			3: return int'($urandom_range(8191, 1));
			4: return int'($urandom_range(64, 1));
			default: return 4096;
		endcase
	endfunction

	function automatic int pick_count();
		if ($urandom_range(2) == 0)
			return int'($urandom_range(7));
		return int'(CNT_ALPHA);
	endfunction

	// main stimulus
	initial begin
		arst_n           = 1'b0;
		psel             = 1'b0;
		penable          = 1'b0;
		pwrite           = 1'b0;
		paddr            = '0;
		pwdata           = '0;
		pix_in.valid     = 1'b0;
		pix_in.src_col   = '0;
		pix_in.src_row   = '0;
		pix_in.src_red   = '0;
		pix_in.src_green = '0;
		pix_in.src_blue  = '0;
		pix_in.src_alpha = '0;
		pix_in.dst_red   = '0;
		pix_in.dst_green = '0;
		pix_in.dst_blue  = '0;
		pix_in.dst_alpha = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// registers at reset: copy, zero alpha, blends and saturation
		send_pair(make_pair(0, 0, 255, 255, 255, 255, 0, 0, 0, 255));
		send_pair(make_pair(4095, 4095, 10, 20, 30, 253, 200, 100, 50, 253));
		send_pair(make_pair(17, 33, 255, 255, 255, 0, 255, 255, 255, 0));
		send_pair(make_pair(5, 6, 200, 100, 50, 1, 90, 80, 70, 2));
		send_pair(make_pair(7, 8, 200, 100, 50, 3, 90, 80, 70, 0));
		send_pair(make_pair(9, 10, 255, 0, 128, 128, 0, 255, 64, 200));
		send_pair(make_pair(11, 12, 40, 50, 60, 254, 1, 2, 3, 252));
		send_pair(make_pair(13, 14, 40, 50, 60, 0, 1, 2, 255, 255));
		send_pair(make_pair(15, 16, 255, 255, 255, 1, 255, 255, 255, 3));
		send_pair(make_pair(2730, 1365, 170, 85, 170, 85, 85, 170, 85, 170));
		wait_drained();

		// extreme offsets push every target outside; width above the cap
		set_config(-4096, 4095, 8191, 1, 3, 1);
		send_pair(make_pair(4095, 0, 99, 98, 97, 96, 95, 94, 93, 92));
		send_pair(make_pair(0, 4095, 255, 255, 255, 255, 255, 255, 255, 255));
		wait_drained();

		// clipping edges with a gray source and two destination channels
		set_config(-1, 4095, 4096, 8191, 2, 1);
		send_pair(make_pair(1, 0, 77, 10, 20, 0, 5, 6, 7, 8));
		send_pair(make_pair(0, 0, 77, 10, 20, 0, 5, 6, 7, 8));
		send_pair(make_pair(1, 1, 77, 10, 20, 0, 5, 6, 7, 8));
		send_pair(make_pair(4095, 0, 200, 1, 2, 3, 4, 5, 6, 7));
		wait_drained();

		// zero width; channel counts out of range
		set_config(0, 0, 0, 4096, 0, 7);
		send_pair(make_pair(0, 0, 1, 2, 3, 4, 5, 6, 7, 8));
		wait_drained();
		set_config(0, 0, 5, 3, 7, 0);
		send_pair(make_pair(4, 2, 60, 70, 80, 0, 10, 20, 30, 100));
		send_pair(make_pair(5, 2, 60, 70, 80, 0, 10, 20, 30, 100));
		send_pair(make_pair(4, 3, 60, 70, 80, 0, 10, 20, 30, 100));
		wait_drained();

		// two-channel gray source over alpha, then three-channel source
		set_config(0, 0, 4096, 4096, 4, 2);
		send_pair(make_pair(100, 200, 10, 20, 30, 0, 1, 2, 3, 0));
		wait_drained();
		set_config(0, 0, 4096, 4096, 1, 3);
		send_pair(make_pair(1, 1, 10, 20, 30, 0, 50, 60, 70, 9));
		wait_drained();

		// random phases: receiver idles, then sender idles, then neither
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph < 4) begin
				tx_idle_pct <= 9;
				rx_idle_pct <= 54;
			end else if (ph < 8) begin
				tx_idle_pct <= 54;
				rx_idle_pct <= 9;
			end else begin
				tx_idle_pct <= 0;
				rx_idle_pct <= 0;
			end
			if (ph == 0 || ph == 8)
				set_config(0, 0, 4096, 4096, int'(CNT_ALPHA), int'(CNT_ALPHA));
			else
				set_config(pick_offset(), pick_offset(), pick_dim(), pick_dim(),
					pick_count(), pick_count());
			for (int k = 0; k < PHASE_LEN; k++) begin
				// receiver holds off long enough for the pipe to fill and back up
				if (ph == 8 && k == 20)
					hold_req <= hold_req + 1;
				// sender pauses until the pipe is empty
				if (ph == 9 && k == PHASE_LEN / 2)
					wait_drained();
				send_pair(rand_pair());
			end
			wait_drained();
		end

		if (bad_words == 0 && words_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
